>>> hdl/uer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, widths, register indexes and reset values of the ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned SinceW  = 20;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned TrigW   = 8;
  localparam int unsigned DistW   = 14;
  localparam int unsigned RemW    = 5;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned CfgW    = 20;

  localparam logic [SinceW-1:0] SinceMax = {SinceW{1'b1}};
  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  // Distance is floor(pulse * 5 / 29), kept as a running quotient and remainder.
  localparam logic [RemW:0] RemStep = 6'd5;
  localparam logic [RemW:0] RemDiv  = 6'd29;

  localparam logic [IdxW-1:0] RegPing    = 2'd0;
  localparam logic [IdxW-1:0] RegTrigW   = 2'd1;
  localparam logic [IdxW-1:0] RegTimeout = 2'd2;

  localparam logic [SinceW-1:0] PingReset    = 20'd60000;
  localparam logic [TrigW-1:0]  TrigWReset   = 8'd10;
  localparam logic [TimerW-1:0] TimeoutReset = 16'd30000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [SinceW-1:0] ping_period_us;
    logic [TrigW-1:0]  trigger_width_us;
    logic [TimerW-1:0] echo_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic clear;
    logic saturated;
  } range_ctl_t;

  typedef struct packed {
    logic             trigger_level;
    logic [DistW-1:0] distance_mm;
    logic             reading_valid;
    logic             measure_done;
  } result_t;

endpackage

>>> hdl/uer_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger configuration registers
// Decodes the write port into the ping period, trigger width and timeout.
// ----------------------------------------------------------------------------
module uer_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [uer_pkg::IdxW-1:0]  cfg_index,
  input  logic [uer_pkg::CfgW-1:0]  cfg_data,
  output uer_pkg::cfg_t             cfg
);
  import uer_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ping_period_us   <= PingReset;
      cfg.trigger_width_us <= TrigWReset;
      cfg.echo_timeout_us  <= TimeoutReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegPing:    cfg.ping_period_us   <= cfg_data[SinceW-1:0];
        RegTrigW:   cfg.trigger_width_us <= cfg_data[TrigW-1:0];
        RegTimeout: cfg.echo_timeout_us  <= cfg_data[TimerW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/uer_range.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger distance tracker
// Keeps floor(timer * 5 / 29) and its remainder in step with the phase timer.
// ----------------------------------------------------------------------------
module uer_range (
  input  logic                       clk,
  input  logic                       rst,
  input  uer_pkg::range_ctl_t        ctl,
  output logic [uer_pkg::DistW-1:0]  quotient_next
);
  import uer_pkg::*;

  logic [DistW-1:0] quotient;
  logic [RemW-1:0]  remainder;
  logic [RemW-1:0]  remainder_next;
  logic [RemW:0]    rem_sum;
  logic             carry;

  always_comb begin
    rem_sum = {1'b0, remainder} + RemStep;
    carry   = !ctl.saturated && (rem_sum >= RemDiv);
    if (ctl.saturated) begin
      remainder_next = remainder;
    end else if (carry) begin
      remainder_next = RemW'(rem_sum - RemDiv);
    end else begin
      remainder_next = rem_sum[RemW-1:0];
    end
    quotient_next = carry ? quotient + DistW'(1) : quotient;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient  <= '0;
      remainder <= '0;
    end else if (ctl.advance) begin
      if (ctl.clear) begin
        quotient  <= '0;
        remainder <= '0;
      end else begin
        quotient  <= quotient_next;
        remainder <= remainder_next;
      end
    end
  end

endmodule

>>> hdl/uer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger sequencer
// Four-phase trigger and echo sequencer with saturating time counters.
// ----------------------------------------------------------------------------
module uer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       echo,
  input  uer_pkg::cfg_t              cfg,
  input  logic [uer_pkg::DistW-1:0]  quotient_next,
  output uer_pkg::range_ctl_t        range_ctl,
  output uer_pkg::result_t           result
);
  import uer_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [SinceW-1:0] since_last_end;
  logic [SinceW-1:0] since_next;
  logic [SinceW-1:0] since_inc;
  logic [TimerW-1:0] phase_timer;
  logic [TimerW-1:0] timer_next;
  logic [TimerW-1:0] timer_inc;
  logic [DistW-1:0]  stored_distance;
  logic [DistW-1:0]  distance_next;
  logic              stored_valid;
  logic              valid_next;
  logic              done;
  logic              timer_clear;
  logic              timed_out;

  always_comb begin
    since_inc = (since_last_end == SinceMax) ? since_last_end
                                             : since_last_end + SinceW'(1);
    timer_inc = (phase_timer == TimerMax) ? phase_timer : phase_timer + TimerW'(1);
    timed_out = timer_inc >= cfg.echo_timeout_us;

    phase_next    = phase;
    since_next    = since_inc;
    timer_clear   = 1'b0;
    distance_next = stored_distance;
    valid_next    = stored_valid;
    done          = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (since_inc >= cfg.ping_period_us) begin
          timer_clear = 1'b1;
          phase_next  = PH_TRIG;
        end
      end
      PH_TRIG: begin
        if (timer_inc >= {{(TimerW-TrigW){1'b0}}, cfg.trigger_width_us}) begin
          phase_next = PH_RISE;
        end
      end
      PH_RISE: begin
        if (echo) begin
          timer_clear = 1'b1;
          phase_next  = PH_FALL;
        end else if (timed_out) begin
          valid_next = 1'b0;
          since_next = '0;
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_FALL: begin
        if (!echo) begin
          distance_next = quotient_next;
          valid_next    = 1'b1;
          since_next    = '0;
          phase_next    = PH_IDLE;
          done          = 1'b1;
        end else if (timed_out) begin
          valid_next = 1'b0;
          since_next = '0;
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    timer_next = timer_clear ? '0 : timer_inc;

    range_ctl.advance   = advance;
    range_ctl.clear     = timer_clear;
    range_ctl.saturated = phase_timer == TimerMax;

    result.trigger_level = phase_next == PH_TRIG;
    result.distance_mm   = distance_next;
    result.reading_valid = valid_next;
    result.measure_done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      since_last_end  <= '0;
      phase_timer     <= '0;
      stored_distance <= '0;
      stored_valid    <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      since_last_end  <= since_next;
      phase_timer     <= timer_next;
      stored_distance <= distance_next;
      stored_valid    <= valid_next;
    end
  end

endmodule

>>> hdl/ultrasonic_echo_ranger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Drives the trigger pin and times the echo pulse, one tick per input beat.
// ----------------------------------------------------------------------------
//   Channel  Beat taken when          Payload
//   in       in_valid && !in_stall    echo_level
//   out      out_valid && !out_stall  trigger_level, distance_mm,
//                                     reading_valid, measure_done
//   cfg      cfg_write                cfg_index, cfg_data
//
// One beat per cycle is sustained while out_stall stays low; a taken beat is held
// in the input register, and its result is then held in the result register.
// Distance comes from a running quotient, so no divider sits in the path.
// Reset is synchronous; no clearing pass follows it.
// A stalled result holds, and one further input beat is taken behind it.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      echo_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      trigger_level,
  output logic [uer_pkg::DistW-1:0] distance_mm,
  output logic                      reading_valid,
  output logic                      measure_done,
  input  logic                      cfg_write,
  input  logic [uer_pkg::IdxW-1:0]  cfg_index,
  input  logic [uer_pkg::CfgW-1:0]  cfg_data
);
  import uer_pkg::*;

  cfg_t             cfg;
  range_ctl_t       range_ctl;
  result_t          result;
  result_t          out_reg;
  logic [DistW-1:0] quotient_next;
  logic             hold_valid;
  logic             hold_echo;
  logic             advance;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_echo <= echo_level;
    end
    if (advance) begin
      out_reg <= result;
    end
  end

  uer_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_range u_range (
    .clk           (clk),
    .rst           (rst),
    .ctl           (range_ctl),
    .quotient_next (quotient_next)
  );

  uer_core u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .echo          (hold_echo),
    .cfg           (cfg),
    .quotient_next (quotient_next),
    .range_ctl     (range_ctl),
    .result        (result)
  );

  assign trigger_level = out_reg.trigger_level;
  assign distance_mm   = out_reg.distance_mm;
  assign reading_valid = out_reg.reading_valid;
  assign measure_done  = out_reg.measure_done;

endmodule

>>> hdl/uer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module uer_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      trigger_level,
  input logic [uer_pkg::DistW-1:0] distance_mm,
  input logic                      reading_valid,
  input logic                      measure_done
);
  import uer_pkg::*;

  localparam logic [DistW-1:0] DistMax = 14'd11299;

  logic [DistW-1:0] last_distance;
  logic             last_valid;
  logic             beat;

  assign beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
      last_valid    <= 1'b0;
    end else if (beat) begin
      last_distance <= distance_mm;
      last_valid    <= reading_valid;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result beat shown straight after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_mm)
      && $stable(measure_done))
    else $error("Stalled result beat changed.");

  a_done_no_trigger: assert property (@(posedge clk) disable iff (rst)
    out_valid && measure_done |-> !trigger_level)
    else $error("Trigger high on the beat a measurement ends.");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_mm <= DistMax)
    else $error("Distance beyond the longest pulse.");

  a_steady_between: assert property (@(posedge clk) disable iff (rst)
    out_valid && !measure_done |-> distance_mm == last_distance
      && reading_valid == last_valid)
    else $error("Reading changed without a finished measurement.");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .trigger_level (trigger_level),
  .distance_mm   (distance_mm),
  .reading_valid (reading_valid),
  .measure_done  (measure_done)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Feeds echo ticks through the valid/stall channels with random gaps and
// stalls, predicts every result beat with a tick-by-tick model of the ranging
// sequencer, and compares the beats field by field. Settings run from the
// register extremes to short ranging loops.
// ----------------------------------------------------------------------------
import uer_pkg::*;

class echo_range_scoreboard;
  logic [SinceW-1:0] ping_us;
  logic [TrigW-1:0]  trig_us;
  logic [TimerW-1:0] timeout_us;
  phase_t            phase;
  logic [SinceW-1:0] since_end;
  logic [TimerW-1:0] timer;
  logic [DistW-1:0]  dist_mm;
  logic              dist_good;
  result_t           expected_ticks[$];
  int                mismatches;

  function new();
    ping_us    = PingReset;
    trig_us    = TrigWReset;
    timeout_us = TimeoutReset;
    phase      = PH_IDLE;
    since_end  = '0;
    timer      = '0;
    dist_mm    = '0;
    dist_good  = 1'b0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      RegPing:    ping_us    = data[SinceW-1:0];
      RegTrigW:   trig_us    = data[TrigW-1:0];
      RegTimeout: timeout_us = data[TimerW-1:0];
      default: ;
    endcase
  endfunction

  function void end_measurement(bit good);
    int unsigned mm;
    if (good) begin
      mm        = (int'(timer) * 10) / 58;
      dist_mm   = mm[DistW-1:0];
      dist_good = 1'b1;
    end else begin
      dist_good = 1'b0;
    end
    since_end = '0;
    phase     = PH_IDLE;
  endfunction

  function void take_tick(logic echo);
    result_t r;
    bit      done;
    done = 1'b0;
    if (since_end != SinceMax) since_end++;
    if (timer != TimerMax) timer++;
    case (phase)
      PH_IDLE: begin
        if (since_end >= ping_us) begin
          timer = '0;
          phase = PH_TRIG;
        end
      end
      PH_TRIG: begin
        if (timer >= TimerW'(trig_us)) phase = PH_RISE;
      end
      PH_RISE: begin
        if (echo) begin
          timer = '0;
          phase = PH_FALL;
        end else if (timer >= timeout_us) begin
          end_measurement(1'b0);
          done = 1'b1;
        end
      end
      default: begin
        if (!echo) begin
          end_measurement(1'b1);
          done = 1'b1;
        end else if (timer >= timeout_us) begin
          end_measurement(1'b0);
          done = 1'b1;
        end
      end
    endcase
    r.trigger_level = (phase == PH_TRIG);
    r.distance_mm   = dist_mm;
    r.reading_valid = dist_good;
    r.measure_done  = done;
    expected_ticks.push_back(r);
  endfunction

  function void field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void match_result(result_t got);
    result_t want;
    if (expected_ticks.size() == 0) begin
      $display("time %0t: result beat with no tick outstanding, expected none, actual %h",
               $time, got);
      mismatches++;
      return;
    end
    want = expected_ticks.pop_front();
    field_check("trigger_level", 32'(want.trigger_level), 32'(got.trigger_level));
    field_check("distance_mm", 32'(want.distance_mm), 32'(got.distance_mm));
    field_check("reading_valid", 32'(want.reading_valid), 32'(got.reading_valid));
    field_check("measure_done", 32'(want.measure_done), 32'(got.measure_done));
  endfunction

  function int outstanding();
    return expected_ticks.size();
  endfunction
endclass

module tb;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 5000;
  localparam logic [IdxW-1:0] RegNone   = 2'd3;
  localparam bit [15:0] ZeroCfgEchoes   = 16'b0110_0011_1000_1101;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic             echo_level = 1'b0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic             trigger_level;
  logic [DistW-1:0] distance_mm;
  logic             reading_valid;
  logic             measure_done;
  logic             cfg_write  = 1'b0;
  logic [IdxW-1:0]  cfg_index  = RegPing;
  logic [CfgW-1:0]  cfg_data   = '0;

  echo_range_scoreboard ranger_sb = new();
  result_t     seen_beat;
  bit          gaps_on    = 1'b1;
  bit          stall_free = 1'b0;
  bit          hold_req   = 1'b0;
  bit          noisy_meas = 1'b0;
  int unsigned meas_ticks = 0;
  int unsigned rise_delay = 0;
  int unsigned pulse_len  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ph_ping, ph_trig, ph_tmo, ph_items;
  int unsigned stall_pick, stall_len;

  ultrasonic_echo_ranger_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .echo_level    (echo_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .distance_mm   (distance_mm),
    .reading_valid (reading_valid),
    .measure_done  (measure_done),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen_beat = {trigger_level, distance_mm, reading_valid, measure_done};
        ranger_sb.match_result(seen_beat);
      end
      if (in_valid && !in_stall) ranger_sb.take_tick(echo_level);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Plans each measurement as a quiet stretch followed by one echo pulse,
  // with the odd measurement filled with noise instead.
  function automatic logic pick_echo();
    int unsigned tmo;
    logic        e;
    tmo = 32'(ranger_sb.timeout_us);
    if (ranger_sb.phase == PH_IDLE || ranger_sb.phase == PH_TRIG) begin
      meas_ticks = 0;
      rise_delay = $urandom_range(0, tmo + 2);
      pulse_len  = $urandom_range(1, tmo + 2);
      noisy_meas = ($urandom_range(0, 9) == 0);
      return 1'($urandom_range(0, 1));
    end
    if (noisy_meas) e = 1'($urandom_range(0, 1));
    else e = (meas_ticks >= rise_delay) && (meas_ticks < rise_delay + pulse_len);
    meas_ticks++;
    return e;
  endfunction

  task automatic send_tick(input logic e);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    echo_level <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ranger_sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    ranger_sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_free) begin
        out_stall <= 1'b0;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 65) begin
          out_stall <= 1'b0;
          stall_len = $urandom_range(1, 8);
        end else if (stall_pick < 95) begin
          out_stall <= 1'b1;
          stall_len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          stall_len = $urandom_range(15, 50);
        end
        repeat (stall_len - 1) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    wait_drained();
    set_reg(RegPing, '0);
    set_reg(RegTrigW, '0);
    set_reg(RegTimeout, '0);
    for (int i = 15; i >= 0; i--) send_tick(ZeroCfgEchoes[i]);

    wait_drained();
    set_reg(RegNone, '1);
    repeat (4) send_tick(pick_echo());

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: begin
          ph_ping = $urandom_range(0, 3);
          ph_trig = 1;
          ph_tmo = $urandom_range(5, 30);
          ph_items = 120;
        end
        1: begin
          ph_ping = 0;
          ph_trig = 255;
          ph_tmo = 8;
          ph_items = 300;
        end
        2, 3: begin
          ph_ping = $urandom_range(0, 20);
          ph_trig = $urandom_range(1, 6);
          ph_tmo = $urandom_range(1, 40);
          ph_items = (p == 2) ? 100 : 120;
        end
        4: begin
          ph_ping = 2;
          ph_trig = 2;
          ph_tmo = 1;
          ph_items = 80;
        end
        default: begin
          ph_ping = $urandom_range(0, 10);
          ph_trig = $urandom_range(0, 4);
          ph_tmo = $urandom_range(100, 300);
          ph_items = 230;
        end
      endcase
      set_reg(RegPing, CfgW'(ph_ping));
      set_reg(RegTrigW, CfgW'(ph_trig));
      set_reg(RegTimeout, CfgW'(ph_tmo));
      gaps_on = (p != 2);
      stall_free = (p == 2);
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < ph_items; k++) begin
        if (p == 3 && k == ph_items / 2) wait_drained();
        send_tick(pick_echo());
      end
    end
    stall_free = 1'b0;
    gaps_on = 1'b1;

    wait_drained();
    set_reg(RegPing, '1);
    repeat (20) send_tick(pick_echo());

    wait_drained();
    repeat (10) @(negedge clk);
    if (ranger_sb.mismatches == 0 && ranger_sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
